// File: rtl/core/assert_macros.svh
// assertion helpers shared by the matcher modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SDM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define SDM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sdm_pkg.sv
package sdm_pkg;

    localparam int PIX_W        = 8;
    localparam int PERIOD_W     = 8;
    localparam int DIST_W       = 7;
    localparam int MIN_PERIOD   = 4;
    localparam int RESET_PERIOD = 64;

    localparam logic [7:0] DEPTH_MAX = 8'd255;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t pixel;
        logic row_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] depth;
        logic       row_last;
        logic       short_row;
    } out_item_t;

    // controls broadcast along the cell chain
    typedef struct packed {
        logic store_shift;
        logic search_load;
        logic search_shift;
    } cell_ctrl_t;

    // controls for the match unit
    typedef struct packed {
        logic              clear;
        logic              sample;
        logic [DIST_W-1:0] shift_idx;
    } match_ctrl_t;

    // 255 / q for q = period / 4, index 0 unused
    localparam logic [7:0] SCALE_LUT [0:63] = '{
        8'd0,   8'd255, 8'd127, 8'd85,  8'd63,  8'd51,  8'd42,  8'd36,
        8'd31,  8'd28,  8'd25,  8'd23,  8'd21,  8'd19,  8'd18,  8'd17,
        8'd15,  8'd15,  8'd14,  8'd13,  8'd12,  8'd12,  8'd11,  8'd11,
        8'd10,  8'd10,  8'd9,   8'd9,   8'd9,   8'd8,   8'd8,   8'd8,
        8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd6,   8'd6,   8'd6,
        8'd6,   8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd5,   8'd5,   8'd5,   8'd4,   8'd4,   8'd4,   8'd4,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4
    };

endpackage

// File: rtl/core/row_sad_depth_matcher.sv
// Stereogram row depth matcher. Pixels enter in raster order on the s_ channel,
// one transfer each, with row_end on the last pixel of a row; depth values leave
// on the m_ channel. The last period+window pixels sit in a chain of cells. For
// a pixel that completes a window, the chain is copied into a search line that
// steps one place per clock: an alignment phase, then a search phase in which
// each step scores one shift by sum of absolute differences. The column then
// passes a finish, a scale and an output state, which waits until the output
// register is free; the next pixel is taken in the same cycle as the result is
// presented. Pixels that produce no result are taken in idle; a row end emits
// its trailing zero results, each once the output is free. The next pixel is
// taken while the last result still waits in the output register. repeat_period
// must be written through cfg_we/cfg_wdata while idle; the block does not
// enforce this, and the depth scale is looked up at that write.
module row_sad_depth_matcher #(
    parameter int MATCH_WIDTH = 8,
    parameter int MAX_PERIOD  = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  sdm_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output sdm_pkg::out_item_t  m_item
);
    import sdm_pkg::*;
    `include "assert_macros.svh"

    localparam int STORE     = MAX_PERIOD + MATCH_WIDTH;
    localparam int CC_W      = $clog2(STORE + 1);
    localparam int TRAIL_W   = $clog2(MATCH_WIDTH + 1);
    localparam int PROD_W    = DIST_W + 8;
    localparam int PCLIP     = (MAX_PERIOD > 255) ? 255 : MAX_PERIOD;
    localparam int RESET_EFF = (RESET_PERIOD > PCLIP) ? PCLIP : RESET_PERIOD;
    localparam logic [7:0] RESET_SCALE = SCALE_LUT[RESET_EFF / 4];

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PRE    = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_FINISH = 7'b0001000,
        ST_SCALE  = 7'b0010000,
        ST_OUT    = 7'b0100000,
        ST_TRAIL  = 7'b1000000
    } state_t;

    // period clamped to the supported range
    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] rp);
        logic [PERIOD_W-1:0] p;
        p = rp;
        if (p < PERIOD_W'(MIN_PERIOD)) p = PERIOD_W'(MIN_PERIOD);
        if (p > PERIOD_W'(PCLIP)) p = PERIOD_W'(PCLIP);
        return p;
    endfunction

    state_t               state_reg, state_next;
    logic [CC_W-1:0]      cc_reg, cc_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [7:0]           scale_reg, scale_next;
    logic [DIST_W-1:0]    cnt_reg, cnt_next;
    logic [TRAIL_W-1:0]   trail_reg, trail_next;
    logic                 short_reg, short_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;

    logic [PERIOD_W-1:0]  per;
    logic [PERIOD_W-1:0]  cfg_per;
    logic [DIST_W-1:0]    half;
    logic [PERIOD_W-1:0]  pre_len;
    logic [CC_W-1:0]      need;
    logic [CC_W-1:0]      cc_inc;
    logic                 out_free;
    logic [DIST_W-1:0]    best_dist;
    cell_ctrl_t           cell_ctrl;
    match_ctrl_t          mctrl;

    pix_t store_px  [STORE];
    pix_t search_px [STORE];
    pix_t a_px      [MATCH_WIDTH];
    pix_t b_px      [MATCH_WIDTH];

    // period derived values
    assign per     = eff_period(period_reg);
    assign cfg_per = eff_period(cfg_wdata);
    assign half    = per[PERIOD_W-1:1];
    assign pre_len = per - {1'b0, per[PERIOD_W-1:1]} - PERIOD_W'(1);
    assign need    = CC_W'(per) + CC_W'(MATCH_WIDTH);
    assign cc_inc  = (cc_reg < CC_W'(STORE)) ? cc_reg + CC_W'(1) : cc_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // cell chain: line store toward older pixels, search line toward the head
    for (genvar j = 0; j < STORE; j++) begin : g_cell
        pix_t store_in;
        pix_t search_in;
        if (j == 0) begin : g_head
            assign store_in = s_item.pixel;
        end else begin : g_body
            assign store_in = store_px[j-1];
        end
        if (j == STORE - 1) begin : g_tail
            assign search_in = '0;
        end else begin : g_inner
            assign search_in = search_px[j+1];
        end
        sdm_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .store_in   (store_in),
            .store_out  (store_px[j]),
            .search_in  (search_in),
            .search_out (search_px[j])
        );
    end

    // fixed taps: reference window at the head, candidate window on the search line
    for (genvar i = 0; i < MATCH_WIDTH; i++) begin : g_tap
        assign a_px[i] = search_px[MATCH_WIDTH - i];
        assign b_px[i] = store_px[MATCH_WIDTH - 1 - i];
    end

    sdm_match #(
        .MATCH_WIDTH (MATCH_WIDTH)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mctrl),
        .a_px      (a_px),
        .b_px      (b_px),
        .best_dist (best_dist)
    );

    // configuration write, scale looked up from the clamped period
    always_comb begin
        period_next = period_reg;
        scale_next  = scale_reg;
        if (cfg_we) begin
            period_next = cfg_wdata;
            scale_next  = SCALE_LUT[cfg_per[PERIOD_W-1:2]];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cc_next         = cc_reg;
        cnt_next        = cnt_reg;
        trail_next      = trail_reg;
        short_next      = short_reg;
        prod_next       = prod_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        cell_ctrl       = '0;
        mctrl           = '0;
        mctrl.shift_idx = cnt_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cell_ctrl.store_shift = 1'b1;
                    if (s_item.row_end) begin
                        cc_next    = '0;
                        state_next = ST_TRAIL;
                        if (cc_inc < need) begin
                            short_next = 1'b1;
                            if (cc_inc > CC_W'(per)) begin
                                trail_next = TRAIL_W'(cc_inc - CC_W'(per));
                            end else begin
                                trail_next = TRAIL_W'(1);
                            end
                        end else begin
                            short_next = 1'b0;
                            trail_next = TRAIL_W'(MATCH_WIDTH);
                        end
                    end else begin
                        cc_next = cc_inc;
                        if (cc_inc >= need) begin
                            cell_ctrl.search_load = 1'b1;
                            mctrl.clear           = 1'b1;
                            cnt_next              = pre_len[DIST_W-1:0];
                            state_next            = ST_PRE;
                        end
                    end
                end
            end
            ST_PRE: begin
                cell_ctrl.search_shift = 1'b1;
                if (cnt_reg == '0) begin
                    cnt_next   = half - DIST_W'(1);
                    state_next = ST_SEARCH;
                end else begin
                    cnt_next = cnt_reg - DIST_W'(1);
                end
            end
            ST_SEARCH: begin
                cell_ctrl.search_shift = 1'b1;
                mctrl.sample           = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg - DIST_W'(1);
                end
            end
            ST_FINISH: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                prod_next  = PROD_W'(best_dist) * PROD_W'(scale_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_item_next.row_last  = 1'b0;
                    m_item_next.short_row = 1'b0;
                    if (prod_reg > PROD_W'(DEPTH_MAX)) begin
                        m_item_next.depth = DEPTH_MAX;
                    end else begin
                        m_item_next.depth = prod_reg[7:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_TRAIL: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_item_next.depth     = '0;
                    m_item_next.row_last  = (trail_reg == TRAIL_W'(1));
                    m_item_next.short_row = short_reg;
                    trail_next            = trail_reg - TRAIL_W'(1);
                    if (trail_reg == TRAIL_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cc_reg      <= '0;
            period_reg  <= PERIOD_W'(RESET_PERIOD);
            scale_reg   <= RESET_SCALE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cc_reg      <= cc_next;
            period_reg  <= period_next;
            scale_reg   <= scale_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        trail_reg  <= trail_next;
        short_reg  <= short_next;
        prod_reg   <= prod_next;
        m_item_reg <= m_item_next;
    end

    `SDM_ASSERT_IMP(a_trail_zero_depth, aclk, aresetn, m_valid && (m_item.row_last || m_item.short_row), m_item.depth == '0, "trailing result with nonzero depth")
    `SDM_ASSERT_IMP(a_search_in_range, aclk, aresetn, state_reg == ST_SEARCH, cnt_reg < half, "search shift beyond half period")
    `SDM_ASSERT_IMP(a_trail_nonempty, aclk, aresetn, state_reg == ST_TRAIL, trail_reg != '0, "empty trailing run")

endmodule

// File: rtl/core/sdm_cell.sv
module sdm_cell (
    input  logic               aclk,
    input  sdm_pkg::cell_ctrl_t ctrl,
    input  sdm_pkg::pix_t      store_in,
    output sdm_pkg::pix_t      store_out,
    input  sdm_pkg::pix_t      search_in,
    output sdm_pkg::pix_t      search_out
);
    import sdm_pkg::*;

    pix_t store_reg;
    pix_t search_reg;

    // line store tap: moves one place older on every pixel transfer
    always_ff @(posedge aclk) begin
        if (ctrl.store_shift) begin
            store_reg <= store_in;
        end
    end

    // search tap: snapshot of the updated store, then walks toward the head
    always_ff @(posedge aclk) begin
        if (ctrl.search_load) begin
            search_reg <= store_in;
        end else if (ctrl.search_shift) begin
            search_reg <= search_in;
        end
    end

    assign store_out  = store_reg;
    assign search_out = search_reg;

endmodule

// File: rtl/core/sdm_match.sv
module sdm_match #(
    parameter int MATCH_WIDTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sdm_pkg::match_ctrl_t          ctrl,
    input  sdm_pkg::pix_t                 a_px [MATCH_WIDTH],
    input  sdm_pkg::pix_t                 b_px [MATCH_WIDTH],
    output logic [sdm_pkg::DIST_W-1:0]    best_dist
);
    import sdm_pkg::*;
    `include "assert_macros.svh"

    localparam int SAD_W = $clog2(MATCH_WIDTH * 255 + 1);

    logic [SAD_W-1:0]  sad;
    logic [SAD_W-1:0]  stage_sad_reg;
    logic [DIST_W-1:0] stage_dist_reg;
    logic              stage_valid_reg;
    logic [SAD_W-1:0]  best_sad_reg;
    logic [DIST_W-1:0] best_dist_reg;

    // sum of absolute differences over the window
    always_comb begin
        sad = '0;
        for (int i = 0; i < MATCH_WIDTH; i++) begin
            if (a_px[i] > b_px[i]) begin
                sad = sad + SAD_W'(a_px[i] - b_px[i]);
            end else begin
                sad = sad + SAD_W'(b_px[i] - a_px[i]);
            end
        end
    end

    // stage register between the adder and the compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= ctrl.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sample) begin
            stage_sad_reg  <= sad;
            stage_dist_reg <= ctrl.shift_idx;
        end
    end

    // shifts arrive in descending order, so an equal sum moves to the smaller shift
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            best_sad_reg  <= '1;
            best_dist_reg <= '0;
        end else if (stage_valid_reg && (stage_sad_reg <= best_sad_reg)) begin
            best_sad_reg  <= stage_sad_reg;
            best_dist_reg <= stage_dist_reg;
        end
    end

    assign best_dist = best_dist_reg;

    `SDM_ASSERT_NXT(a_best_not_worse, aclk, aresetn, stage_valid_reg, best_sad_reg <= $past(stage_sad_reg), "best sum above a sampled sum")

endmodule
